>>> rtl/core/smx_pkg.sv
// ----------------------------------------------------------------------------
// smx_pkg
// Opcodes, fault codes, fixed widths and shared types of the stack machine
// execute block.
// ----------------------------------------------------------------------------
package smx_pkg;

	localparam int WORD_W        = 32;
	localparam int KIND_W        = 4;
	localparam int FAULT_W       = 3;
	localparam int PROGRAM_LINES = 4096;
	localparam int LINE_W        = $clog2(PROGRAM_LINES);

	typedef enum logic [KIND_W-1:0] {
		OP_RES      = 4'd0,
		OP_READ     = 4'd1,
		OP_WRITE    = 4'd2,
		OP_LOADVAR  = 4'd3,
		OP_LOADINT  = 4'd4,
		OP_LT       = 4'd5,
		OP_GT       = 4'd6,
		OP_EQ       = 4'd7,
		OP_JMPFALSE = 4'd8,
		OP_GOTO     = 4'd9,
		OP_STORE    = 4'd10,
		OP_ADD      = 4'd11,
		OP_MUL      = 4'd12,
		OP_SUB      = 4'd13,
		OP_DIV      = 4'd14,
		OP_HALT     = 4'd15
	} kind_t;

	typedef enum logic [FAULT_W-1:0] {
		FLT_NONE  = 3'd0,
		FLT_UNDER = 3'd1,
		FLT_OVER  = 3'd2,
		FLT_ADDR  = 3'd3,
		FLT_DIVZ  = 3'd4
	} fault_t;

	// Request from the sequencer to the arithmetic unit.
	typedef struct packed {
		logic  start;
		kind_t op;
	} alu_req_t;

endpackage

>>> rtl/core/smx_alu.sv
// ----------------------------------------------------------------------------
// smx_alu
// Arithmetic and compare unit with a registered result:
// add, subtract, multiply (low word) and signed lt / gt / eq.
// ----------------------------------------------------------------------------
module smx_alu
	import smx_pkg::*;
(
	input  logic              clk,
	input  alu_req_t          req,
	input  logic [WORD_W-1:0] a,
	input  logic [WORD_W-1:0] b,
	output logic [WORD_W-1:0] result
);

	logic [WORD_W-1:0] result_d;
	logic [WORD_W-1:0] result_q;

	always_comb begin
		case (req.op)
			OP_LT:   result_d = ($signed(a) < $signed(b)) ? WORD_W'(1) : '0;
			OP_GT:   result_d = ($signed(a) > $signed(b)) ? WORD_W'(1) : '0;
			OP_EQ:   result_d = (a == b) ? WORD_W'(1) : '0;
			OP_ADD:  result_d = a + b;
			OP_SUB:  result_d = a - b;
			OP_MUL:  result_d = a * b;
			default: result_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			result_q <= result_d;
		end
	end

	assign result = result_q;

endmodule

>>> rtl/core/smx_div.sv
// ----------------------------------------------------------------------------
// smx_div
// Iterative signed divider, one quotient bit per cycle. The quotient
// truncates toward zero; the most negative value over minus one wraps.
// ----------------------------------------------------------------------------
module smx_div
	import smx_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WORD_W-1:0] a,
	input  logic [WORD_W-1:0] b,
	output logic              done,
	output logic [WORD_W-1:0] quotient
);

	localparam int STEP_W = $clog2(WORD_W);

	logic              busy_q;
	logic              done_q;
	logic              neg_q;
	logic [STEP_W-1:0] step_q;
	logic [WORD_W-1:0] quo_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] div_q;
	logic [WORD_W-1:0] shifted;
	logic [WORD_W:0]   trial;

	// The remainder stays below the divisor, which is at most 2^31, so the
	// shifted remainder always fits in one word.
	assign shifted = {rem_q[WORD_W-2:0], quo_q[WORD_W-1]};
	assign trial   = {1'b0, shifted} - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(WORD_W - 1);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= a[WORD_W-1] ? (WORD_W'(0) - a) : a;
			div_q <= b[WORD_W-1] ? (WORD_W'(0) - b) : b;
			rem_q <= '0;
			neg_q <= a[WORD_W-1] ^ b[WORD_W-1];
		end else if (busy_q) begin
			if (!trial[WORD_W]) begin
				rem_q <= trial[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[WORD_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (WORD_W'(0) - quo_q) : quo_q;

endmodule

>>> rtl/core/stack_machine_execute_top.sv
// ----------------------------------------------------------------------------
// stack_machine_execute_top
// Executes one instruction of a 32-bit integer stack machine per item.
// ----------------------------------------------------------------------------
// Each input item is one instruction; each answers with exactly one result
// item carrying the next line, an optional write value, the halt state and a
// fault code. Most instructions pass through decode with the memory reads,
// execute and the result register, which is loaded once the previous result
// has been taken; lt, gt, eq, add, sub and mul also pass through the
// arithmetic register, and div waits for the bit-per-cycle divider.
// The top of stack lives in a register and the rest of the stack in a
// single-port-read memory, so a binary operation needs only one memory
// read. A res instruction of size n runs a clearing pass over the data
// memory, one word a cycle, before its result appears; the memory needs no
// pass after reset because the data size is then zero. A new item is
// accepted as soon as the previous one has moved into the result register,
// even if that result is still waiting to be taken.
module stack_machine_execute_top
	import smx_pkg::*;
#(
	parameter int STACK_DEPTH = 64,
	parameter int DATA_WORDS  = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// operand [31:0], current_line [43:32], read_value [75:44], zero fill
	input  logic [79:0] s_axis_tdata,
	// kind [3:0]
	input  logic [3:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// next_line [11:0], write_valid [12], write_value [44:13], halted [45],
	// fault [48:46], zero fill
	output logic [55:0] m_axis_tdata
);

	localparam int CW  = $clog2(STACK_DEPTH + 1);
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int SW  = $clog2(DATA_WORDS + 1);
	localparam int DAW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_DECODE = 7'b0000010,
		ST_EXEC   = 7'b0000100,
		ST_ALU    = 7'b0001000,
		ST_DIV    = 7'b0010000,
		ST_CLEAR  = 7'b0100000,
		ST_DONE   = 7'b1000000
	} state_t;

	state_t            state_q;
	kind_t             kind_q;
	logic [WORD_W-1:0] opnd_q;
	logic [LINE_W-1:0] line_q;
	logic [WORD_W-1:0] rval_q;
	logic [CW-1:0]     count_q;
	logic [WORD_W-1:0] tos_q;
	logic [SW-1:0]     size_q;
	logic [SW-1:0]     clr_q;
	logic              halt_q;
	fault_t            fault_q;
	fault_t            fault_d;

	logic [LINE_W-1:0] res_next_q;
	logic              res_wv_q;
	logic [WORD_W-1:0] res_wval_q;

	logic              out_valid_q;
	logic [LINE_W-1:0] out_next_q;
	logic              out_wv_q;
	logic [WORD_W-1:0] out_wval_q;
	logic              out_halt_q;
	fault_t            out_fault_q;

	logic [WORD_W-1:0] stk_mem [STACK_DEPTH];
	logic [WORD_W-1:0] stk_rd_q;
	logic              stk_we;
	logic [SAW-1:0]    stk_wa;
	logic [WORD_W-1:0] dat_mem [DATA_WORDS];
	logic [WORD_W-1:0] dat_rd_q;
	logic              dat_we;
	logic [DAW-1:0]    dat_wa;
	logic [WORD_W-1:0] dat_wd;

	logic [CW-1:0]     cnt_m1;
	logic [CW-1:0]     cnt_m2;
	logic              exec_ok;
	logic              is_push;
	logic              is_need1;
	logic              is_need2;
	logic              is_addr_op;
	logic              addr_ok;
	logic [LINE_W-1:0] line_inc;
	logic [LINE_W-1:0] jump_line;
	logic              out_free;

	alu_req_t          alu_req;
	logic [WORD_W-1:0] alu_result;
	logic              div_start;
	logic              div_done;
	logic [WORD_W-1:0] div_quot;

	assign cnt_m1    = count_q - CW'(1);
	assign cnt_m2    = count_q - CW'(2);
	assign exec_ok   = (state_q == ST_EXEC) && !halt_q && (fault_q == FLT_NONE);
	assign line_inc  = line_q + LINE_W'(1);
	assign jump_line = opnd_q[LINE_W-1:0] - LINE_W'(1);
	assign out_free  = !out_valid_q || m_axis_tready;

	assign is_push    = (kind_q == OP_LOADVAR) || (kind_q == OP_LOADINT);
	assign is_need1   = (kind_q == OP_WRITE) || (kind_q == OP_STORE) ||
	                    (kind_q == OP_JMPFALSE);
	assign is_need2   = (kind_q == OP_LT) || (kind_q == OP_GT) || (kind_q == OP_EQ) ||
	                    (kind_q == OP_ADD) || (kind_q == OP_MUL) ||
	                    (kind_q == OP_SUB) || (kind_q == OP_DIV);
	assign is_addr_op = (kind_q == OP_READ) || (kind_q == OP_STORE) ||
	                    (kind_q == OP_LOADVAR);
	assign addr_ok    = opnd_q < WORD_W'(size_q);

	// Stack faults take precedence over address faults, which take
	// precedence over division by zero.
	always_comb begin
		fault_d = FLT_NONE;
		if (halt_q) begin
			fault_d = FLT_NONE;
		end else if (is_need1 && (count_q == '0)) begin
			fault_d = FLT_UNDER;
		end else if (is_need2 && (count_q < CW'(2))) begin
			fault_d = FLT_UNDER;
		end else if (is_push && (count_q == CW'(STACK_DEPTH))) begin
			fault_d = FLT_OVER;
		end else if (is_addr_op && !addr_ok) begin
			fault_d = FLT_ADDR;
		end else if ((kind_q == OP_RES) && (opnd_q > WORD_W'(DATA_WORDS))) begin
			fault_d = FLT_ADDR;
		end else if ((kind_q == OP_DIV) && (tos_q == '0)) begin
			fault_d = FLT_DIVZ;
		end
	end

	// A push spills the old top of stack into the memory.
	assign stk_we = exec_ok && is_push && (count_q != '0);
	assign stk_wa = cnt_m1[SAW-1:0];

	always_comb begin
		dat_we = 1'b0;
		dat_wa = opnd_q[DAW-1:0];
		dat_wd = rval_q;
		if (state_q == ST_CLEAR) begin
			dat_we = 1'b1;
			dat_wa = clr_q[DAW-1:0];
			dat_wd = '0;
		end else if (exec_ok && (kind_q == OP_READ)) begin
			dat_we = 1'b1;
		end else if (exec_ok && (kind_q == OP_STORE)) begin
			dat_we = 1'b1;
			dat_wd = tos_q;
		end
	end

	// Items are handled one at a time and every read is issued in the decode
	// cycle, after the previous item's writes, so no forwarding is needed.
	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_wa] <= tos_q;
		end
		if (state_q == ST_DECODE) begin
			stk_rd_q <= stk_mem[cnt_m2[SAW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (dat_we) begin
			dat_mem[dat_wa] <= dat_wd;
		end
		if (state_q == ST_DECODE) begin
			dat_rd_q <= dat_mem[opnd_q[DAW-1:0]];
		end
	end

	assign alu_req.start = exec_ok && is_need2 && (kind_q != OP_DIV);
	assign alu_req.op    = kind_q;
	assign div_start     = exec_ok && (kind_q == OP_DIV);

	smx_alu u_alu (
		.clk    (clk),
		.req    (alu_req),
		.a      (stk_rd_q),
		.b      (tos_q),
		.result (alu_result)
	);

	smx_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.a        (stk_rd_q),
		.b        (tos_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Item capture.
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && s_axis_tvalid) begin
			kind_q <= kind_t'(s_axis_tuser);
			opnd_q <= s_axis_tdata[31:0];
			line_q <= s_axis_tdata[43:32];
			rval_q <= s_axis_tdata[75:44];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			size_q      <= '0;
			clr_q       <= '0;
			halt_q      <= 1'b0;
			fault_q     <= FLT_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					fault_q <= fault_d;
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_DONE;
					if (exec_ok) begin
						case (kind_q)
							OP_RES: begin
								size_q <= opnd_q[SW-1:0];
								clr_q  <= '0;
								if (opnd_q != '0) begin
									state_q <= ST_CLEAR;
								end
							end
							OP_WRITE, OP_STORE: begin
								count_q <= cnt_m1;
							end
							OP_LOADVAR, OP_LOADINT: begin
								count_q <= count_q + CW'(1);
							end
							OP_HALT: begin
								halt_q <= 1'b1;
							end
							OP_DIV: begin
								state_q <= ST_DIV;
							end
							OP_LT, OP_GT, OP_EQ, OP_ADD, OP_MUL, OP_SUB: begin
								state_q <= ST_ALU;
							end
							default: begin
							end
						endcase
					end
				end
				ST_ALU: begin
					count_q <= cnt_m1;
					state_q <= ST_DONE;
				end
				ST_DIV: begin
					if (div_done) begin
						count_q <= cnt_m1;
						state_q <= ST_DONE;
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + SW'(1);
					if (clr_q == (size_q - SW'(1))) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Top of stack and result fields.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_EXEC: begin
				res_next_q <= line_inc;
				res_wv_q   <= 1'b0;
				res_wval_q <= '0;
				if (halt_q) begin
					res_next_q <= line_q;
				end else if (fault_q == FLT_NONE) begin
					case (kind_q)
						OP_WRITE: begin
							res_wv_q   <= 1'b1;
							res_wval_q <= tos_q;
							tos_q      <= stk_rd_q;
						end
						OP_STORE: begin
							tos_q <= stk_rd_q;
						end
						OP_LOADINT: begin
							tos_q <= opnd_q;
						end
						OP_LOADVAR: begin
							tos_q <= dat_rd_q;
						end
						OP_JMPFALSE: begin
							if (tos_q == '0) begin
								res_next_q <= jump_line;
							end
						end
						OP_GOTO: begin
							res_next_q <= jump_line;
						end
						OP_HALT: begin
							res_next_q <= line_q;
						end
						default: begin
						end
					endcase
				end
			end
			ST_ALU: begin
				tos_q <= alu_result;
			end
			ST_DIV: begin
				if (div_done) begin
					tos_q <= div_quot;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_next_q  <= res_next_q;
					out_wv_q    <= res_wv_q;
					out_wval_q  <= res_wval_q;
					out_halt_q  <= halt_q;
					out_fault_q <= fault_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, out_fault_q, out_halt_q, out_wval_q, out_wv_q, out_next_q};

endmodule
